FILE: design/odo_pkg.sv
// Shared types, constants and helper functions of the odometry core.
`timescale 1ns / 1ps

package odo_pkg;

    // Field and datapath widths
    localparam int RPM_W      = 16;
    localparam int DT_W       = 12;
    localparam int POS_W      = 32;
    localparam int HEAD_W     = 31;
    localparam int SCALE_W    = 32;
    localparam int INV_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 6;
    localparam int MUL_A_W    = 64;
    localparam int MUL_B_W    = 32;
    localparam int MUL_W      = 96;
    localparam int DIV_W      = 64;
    localparam int DEN_W      = 31;
    localparam int CORD_W     = 34;
    localparam int ATAN_W     = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK = 2'd1;

    localparam logic [INV_W-1:0] INV_TRACK_RST = 24'd150312;

    // Angle and division constants
    localparam logic [31:0]              PI_Q28      = 32'd843314857;
    localparam logic [DEN_W-1:0]         TWO_PI_Q28  = 31'd1686629713;
    localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CORD_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [DEN_W-1:0]         DIST_DIV    = 31'd32768000;
    localparam logic [DEN_W-1:0]         HEAD_DIV    = 31'd250;

    localparam logic signed [MUL_W-1:0] S32_MAX = 96'sd2147483647;
    localparam logic signed [MUL_W-1:0] S32_MIN = -96'sd2147483648;

    typedef enum logic [4:0] {
        S_IDLE, S_M2, S_M3, S_M4, S_D1, S_M5, S_D2, S_D3, S_W1, S_C1,
        S_M6, S_M7, S_W2, S_C2, S_M8, S_M9, S_M10, S_M11, S_M12, S_DONE,
        S_MUL, S_DIV, S_CORD
    } t_state;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:  v = 31'd843314856;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043836;
            5'd3:  v = 31'd133525158;
            5'd4:  v = 31'd67021686;
            5'd5:  v = 31'd33543515;
            5'd6:  v = 31'd16775850;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194282;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048575;
            5'd11: v = 31'd524287;
            5'd12: v = 31'd262143;
            5'd13: v = 31'd131071;
            5'd14: v = 31'd65535;
            5'd15: v = 31'd32767;
            5'd16: v = 31'd16383;
            5'd17: v = 31'd8191;
            5'd18: v = 31'd4095;
            5'd19: v = 31'd2047;
            5'd20: v = 31'd1023;
            5'd21: v = 31'd511;
            5'd22: v = 31'd255;
            5'd23: v = 31'd127;
            5'd24: v = 31'd63;
            5'd25: v = 31'd31;
            5'd26: v = 31'd15;
            5'd27: v = 31'd7;
            5'd28: v = 31'd3;
            5'd29: v = 31'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Turns a remainder modulo two pi and the sign of the dividend into an
    // angle within plus or minus pi.
    function automatic logic signed [31:0] wrap_fix(input logic [31:0] rem, input logic neg);
        logic signed [32:0] r;
        r = $signed({1'b0, rem});
        if (neg && rem != '0) begin
            r = $signed({2'b0, TWO_PI_Q28}) - r;
        end
        if (r > $signed({1'b0, PI_Q28})) begin
            r = r - $signed({2'b0, TWO_PI_Q28});
        end
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MUL_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? 64'(-v) : 64'(v);
        return r;
    endfunction

endpackage

FILE: design/odo_in_if.sv
// Input channel carrying wheel speeds and elapsed time.
`timescale 1ns / 1ps

interface odo_in_if;
    import odo_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RPM_W-1:0] left_rpm;
    logic signed [RPM_W-1:0] right_rpm;
    logic [DT_W-1:0]         elapsed_ms;

    modport source (output valid, output left_rpm, output right_rpm, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input left_rpm, input right_rpm, input elapsed_ms,
                    output ready);
endinterface

FILE: design/odo_out_if.sv
// Output channel carrying pose, linear speed and yaw rate.
`timescale 1ns / 1ps

interface odo_out_if;
    import odo_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0] heading;
    logic signed [POS_W-1:0]  linear_speed;
    logic signed [POS_W-1:0]  yaw_rate;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output linear_speed, output yaw_rate, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input linear_speed, input yaw_rate, output ready);
endinterface

FILE: design/differential_drive_odometry_core.sv
// Dead-reckoning odometry core for a differential-drive base.
// The bit-serial multiplier (one multiplier bit per cycle) and the bit-serial divider (one
// quotient bit per cycle) carry each item from input transfer to a valid result; one item
// is in work at a time, and a finished result waits in the output register. Reset
// (synchronous, active low) clears pose, heading and configuration to their defaults.
`timescale 1ns / 1ps

module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [odo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    odo_in_if.sink                            i_item,
    odo_out_if.source                         o_pose
);
    import odo_pkg::*;

    // Sequencer. Each step state takes the result of the previous operation
    // of the shared multiplier, divider or CORDIC unit and starts the next;
    // r_ret holds the step that resumes when the unit is finished.
    t_state r_state, n_state, r_ret, n_ret;

    // Configuration registers
    logic [SCALE_W-1:0] r_scale;
    logic [INV_W-1:0]   r_inv;

    // Latched input item
    logic signed [RPM_W-1:0] r_lr, n_lr, r_rr, n_rr;
    logic [DT_W-1:0]         r_dt, n_dt;

    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Bit-serial multiplier: magnitudes with a separate sign.
    logic [MUL_W-1:0]   r_ma, n_ma, r_macc, n_macc;
    logic [MUL_B_W-1:0] r_mb, n_mb;
    logic               r_mneg, n_mneg;

    // Bit-serial restoring divider by a constant divisor.
    logic [DIV_W-1:0] r_dnum, n_dnum;
    logic [31:0]      r_drem, n_drem;
    logic [DEN_W-1:0] r_dden, n_dden;

    // CORDIC in rotation mode, one micro-rotation per cycle.
    logic signed [CORD_W-1:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic                     r_cneg, n_cneg;

    // Intermediate values of the update
    logic signed [48:0]       r_sum, n_sum, r_diff, n_diff;
    logic                     r_qneg, n_qneg, r_wneg, n_wneg;
    logic signed [31:0]       r_d, n_d, r_dth, n_dth;
    logic signed [CORD_W-1:0] r_c, n_c, r_s, n_s, r_dx, n_dx, r_dy, n_dy;
    logic signed [MUL_W-1:0]  r_pa, n_pa;
    logic signed [39:0]       r_xi, n_xi, r_yi, n_yi;
    logic signed [31:0]       r_yaw, n_yaw;

    // Pose state
    logic signed [31:0] r_x, n_x, r_y, n_y, r_head, n_head;

    // Output register
    logic                     r_ovalid, n_ovalid;
    logic signed [POS_W-1:0]  r_ox, n_ox, r_oy, n_oy, r_olin, n_olin, r_oyaw, n_oyaw;
    logic signed [HEAD_W-1:0] r_ohead, n_ohead;

    // Requests to the shared units
    logic                     c_go_mul, c_go_div, c_go_cord;
    logic [MUL_A_W-1:0]       c_mul_a;
    logic [MUL_B_W-1:0]       c_mul_b;
    logic                     c_mul_neg;
    logic [DIV_W-1:0]         c_div_num;
    logic [DEN_W-1:0]         c_div_den;
    logic signed [31:0]       c_cord_ang;
    t_state                   c_ret;

    // Combinational helpers
    logic signed [MUL_W-1:0]  w_mres, c_sh30, c_sh16, c_xd, c_yd, c_xsh, c_ysh;
    logic signed [MUL_W-1:0]  c_xsum, c_ysum, c_lin;
    logic signed [16:0]       c_sa, c_da;
    logic signed [48:0]       c_dh;
    logic signed [32:0]       c_v;
    logic signed [31:0]       c_wrap;
    logic [30:0]              c_dmag;
    logic signed [CORD_W-1:0] w_cos, w_sin, c_z0, c_shx, c_shy, c_atan;
    logic [31:0]              c_rem_sh;
    logic                     c_qbit;
    logic signed [31:0]       c_px, c_py;

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_pose.valid        = r_ovalid;
    assign o_pose.pos_x        = r_ox;
    assign o_pose.pos_y        = r_oy;
    assign o_pose.heading      = r_ohead;
    assign o_pose.linear_speed = r_olin;
    assign o_pose.yaw_rate     = r_oyaw;

    always_comb begin
        // Signed product of the multiplier and the shifted forms in use.
        w_mres = r_mneg ? -$signed(r_macc) : $signed(r_macc);
        c_sh30 = w_mres >>> 30;
        c_sh16 = w_mres >>> 16;
        c_xd   = r_pa - w_mres;
        c_yd   = r_pa + w_mres;
        c_xsh  = c_xd >>> 30;
        c_ysh  = c_yd >>> 30;
        c_sa   = 17'(i_item.left_rpm) + 17'(i_item.right_rpm);
        c_da   = 17'(r_rr) - 17'(r_lr);
        c_dh   = r_diff >>> 16;
        c_v    = 33'(r_head) + 33'(r_dth);
        c_wrap = wrap_fix(r_drem, r_wneg);
        c_dmag = (|r_dnum[63:31]) ? 31'h7FFFFFFF : r_dnum[30:0];
        w_cos  = r_cneg ? -r_cx : r_cx;
        w_sin  = r_cneg ? -r_cy : r_cy;
        c_shx  = r_cx >>> r_cnt[4:0];
        c_shy  = r_cy >>> r_cnt[4:0];
        c_atan = $signed({3'b0, atan_q30(r_cnt[4:0])});
        c_rem_sh = {r_drem[30:0], r_dnum[DIV_W-1]};
        c_qbit   = (c_rem_sh >= {1'b0, r_dden});
        c_px   = sat32(96'(r_x));
        c_py   = sat32(96'(r_y));
        c_xsum = 96'(r_x) + 96'(r_xi);
        c_ysum = 96'(r_y) + 96'(r_yi);
        c_lin  = 96'(r_sum >>> 17);

        n_state = r_state;  n_ret = r_ret;
        n_lr = r_lr;  n_rr = r_rr;  n_dt = r_dt;  n_cnt = r_cnt;
        n_ma = r_ma;  n_mb = r_mb;  n_macc = r_macc;  n_mneg = r_mneg;
        n_dnum = r_dnum;  n_drem = r_drem;  n_dden = r_dden;
        n_cx = r_cx;  n_cy = r_cy;  n_cz = r_cz;  n_cneg = r_cneg;
        n_sum = r_sum;  n_diff = r_diff;  n_qneg = r_qneg;  n_wneg = r_wneg;
        n_d = r_d;  n_dth = r_dth;  n_c = r_c;  n_s = r_s;  n_dx = r_dx;  n_dy = r_dy;
        n_pa = r_pa;  n_xi = r_xi;  n_yi = r_yi;  n_yaw = r_yaw;
        n_x = r_x;  n_y = r_y;  n_head = r_head;
        n_ox = r_ox;  n_oy = r_oy;  n_ohead = r_ohead;  n_olin = r_olin;  n_oyaw = r_oyaw;
        n_ovalid = r_ovalid && !o_pose.ready;

        c_go_mul = 1'b0;  c_go_div = 1'b0;  c_go_cord = 1'b0;
        c_mul_a = '0;  c_mul_b = '0;  c_mul_neg = 1'b0;
        c_div_num = '0;  c_div_den = '0;  c_cord_ang = '0;
        c_ret = S_IDLE;
        c_z0 = '0;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_lr = i_item.left_rpm;
                    n_rr = i_item.right_rpm;
                    n_dt = i_item.elapsed_ms;
                    // Wheel speed sum: (left + right) * scale.
                    c_go_mul = 1'b1;
                    c_mul_a = abs64(64'(c_sa));
                    c_mul_b = r_scale;
                    c_mul_neg = c_sa[16];
                    c_ret = S_M2;
                end
            end
            S_M2: begin
                n_sum = w_mres[48:0];
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(c_da));
                c_mul_b = r_scale;
                c_mul_neg = c_da[16];
                c_ret = S_M3;
            end
            S_M3: begin
                n_diff = w_mres[48:0];
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_sum));
                c_mul_b = 32'(r_dt);
                c_mul_neg = r_sum[48];
                c_ret = S_M4;
            end
            S_M4: begin
                // Distance step magnitude: |sum * dt| / (500 * 2^16).
                n_qneg = r_mneg;
                c_go_div = 1'b1;
                c_div_num = r_macc[DIV_W-1:0];
                c_div_den = DIST_DIV;
                c_ret = S_D1;
            end
            S_D1: begin
                n_d = r_qneg ? -$signed({1'b0, c_dmag}) : $signed({1'b0, c_dmag});
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_diff));
                c_mul_b = 32'(r_dt);
                c_mul_neg = r_diff[48];
                c_ret = S_M5;
            end
            S_M5: begin
                n_wneg = r_mneg;
                c_go_mul = 1'b1;
                c_mul_a = {20'b0, r_macc[63:20]};
                c_mul_b = 32'(r_inv);
                c_mul_neg = 1'b0;
                c_ret = S_D2;
            end
            S_D2: begin
                c_go_div = 1'b1;
                c_div_num = r_macc[DIV_W-1:0];
                c_div_den = HEAD_DIV;
                c_ret = S_D3;
            end
            S_D3: begin
                // Reduce the heading step modulo two pi.
                c_go_div = 1'b1;
                c_div_num = r_dnum;
                c_div_den = TWO_PI_Q28;
                c_ret = S_W1;
            end
            S_W1: begin
                n_dth = c_wrap;
                c_go_cord = 1'b1;
                c_cord_ang = c_wrap;
                c_ret = S_C1;
            end
            S_C1: begin
                n_c = w_cos;
                n_s = w_sin;
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_d));
                c_mul_b = MUL_B_W'(abs64(64'(w_cos)));
                c_mul_neg = r_d[31] ^ w_cos[CORD_W-1];
                c_ret = S_M6;
            end
            S_M6: begin
                n_dx = c_sh30[CORD_W-1:0];
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_d));
                c_mul_b = MUL_B_W'(abs64(64'(r_s)));
                c_mul_neg = r_d[31] ^ r_s[CORD_W-1];
                c_ret = S_M7;
            end
            S_M7: begin
                n_dy = c_sh30[CORD_W-1:0];
                // New heading, wrapped through the divider as well.
                n_wneg = c_v[32];
                c_go_div = 1'b1;
                c_div_num = abs64(64'(c_v));
                c_div_den = TWO_PI_Q28;
                c_ret = S_W2;
            end
            S_W2: begin
                n_head = c_wrap;
                c_go_cord = 1'b1;
                c_cord_ang = c_wrap;
                c_ret = S_C2;
            end
            S_C2: begin
                n_c = w_cos;
                n_s = w_sin;
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_dx));
                c_mul_b = MUL_B_W'(abs64(64'(w_cos)));
                c_mul_neg = r_dx[CORD_W-1] ^ w_cos[CORD_W-1];
                c_ret = S_M8;
            end
            S_M8: begin
                n_pa = w_mres;
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_dy));
                c_mul_b = MUL_B_W'(abs64(64'(r_s)));
                c_mul_neg = r_dy[CORD_W-1] ^ r_s[CORD_W-1];
                c_ret = S_M9;
            end
            S_M9: begin
                n_xi = c_xsh[39:0];
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_dx));
                c_mul_b = MUL_B_W'(abs64(64'(r_s)));
                c_mul_neg = r_dx[CORD_W-1] ^ r_s[CORD_W-1];
                c_ret = S_M10;
            end
            S_M10: begin
                n_pa = w_mres;
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(r_dy));
                c_mul_b = MUL_B_W'(abs64(64'(r_c)));
                c_mul_neg = r_dy[CORD_W-1] ^ r_c[CORD_W-1];
                c_ret = S_M11;
            end
            S_M11: begin
                n_yi = c_ysh[39:0];
                // Yaw rate: floor(diff / 2^16) * inverse track width / 2^16.
                c_go_mul = 1'b1;
                c_mul_a = abs64(64'(c_dh));
                c_mul_b = 32'(r_inv);
                c_mul_neg = c_dh[48];
                c_ret = S_M12;
            end
            S_M12: begin
                n_yaw = sat32(c_sh16);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_pose.ready) begin
                    n_x = sat32(c_xsum);
                    n_y = sat32(c_ysum);
                    n_ox = sat32(c_xsum);
                    n_oy = sat32(c_ysum);
                    n_ohead = r_head[HEAD_W-1:0];
                    n_olin = sat32(c_lin);
                    n_oyaw = r_yaw;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_x = c_px;
                    n_y = c_py;
                end
            end
            S_MUL: begin
                n_macc = r_macc + (r_mb[0] ? r_ma : '0);
                n_ma = r_ma << 1;
                n_mb = r_mb >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    n_state = r_ret;
                end
            end
            S_DIV: begin
                n_drem = c_qbit ? (c_rem_sh - {1'b0, r_dden}) : c_rem_sh;
                n_dnum = {r_dnum[DIV_W-2:0], c_qbit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = r_ret;
                end
            end
            S_CORD: begin
                if (!r_cz[CORD_W-1]) begin
                    n_cx = r_cx - c_shy;
                    n_cy = r_cy + c_shx;
                    n_cz = r_cz - c_atan;
                end else begin
                    n_cx = r_cx + c_shy;
                    n_cy = r_cy - c_shx;
                    n_cz = r_cz + c_atan;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (c_go_mul) begin
            n_ma = {32'b0, c_mul_a};
            n_mb = c_mul_b;
            n_macc = '0;
            n_mneg = c_mul_neg;
            n_cnt = '0;
            n_ret = c_ret;
            n_state = S_MUL;
        end
        if (c_go_div) begin
            n_dnum = c_div_num;
            n_drem = '0;
            n_dden = c_div_den;
            n_cnt = '0;
            n_ret = c_ret;
            n_state = S_DIV;
        end
        if (c_go_cord) begin
            // Fold the angle into the right half plane before rotating.
            c_z0 = $signed({c_cord_ang, 2'b00});
            n_cneg = 1'b0;
            n_cz = c_z0;
            if (c_z0 > HALF_PI_Q30) begin
                n_cz = c_z0 - PI_Q30;
                n_cneg = 1'b1;
            end else if (c_z0 < -HALF_PI_Q30) begin
                n_cz = c_z0 + PI_Q30;
                n_cneg = 1'b1;
            end
            n_cx = GAIN_Q30;
            n_cy = '0;
            n_cnt = '0;
            n_ret = c_ret;
            n_state = S_CORD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= '0;
            r_scale  <= '0;
            r_inv    <= INV_TRACK_RST;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_x      <= n_x;
            r_y      <= n_y;
            r_head   <= n_head;
            if (i_cfg_we && i_cfg_idx == REG_SCALE) begin
                r_scale <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_INV_TRACK) begin
                r_inv <= i_cfg_data[INV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;  r_lr <= n_lr;  r_rr <= n_rr;  r_dt <= n_dt;  r_cnt <= n_cnt;
        r_ma <= n_ma;  r_mb <= n_mb;  r_macc <= n_macc;  r_mneg <= n_mneg;
        r_dnum <= n_dnum;  r_drem <= n_drem;  r_dden <= n_dden;
        r_cx <= n_cx;  r_cy <= n_cy;  r_cz <= n_cz;  r_cneg <= n_cneg;
        r_sum <= n_sum;  r_diff <= n_diff;  r_qneg <= n_qneg;  r_wneg <= n_wneg;
        r_d <= n_d;  r_dth <= n_dth;  r_c <= n_c;  r_s <= n_s;  r_dx <= n_dx;  r_dy <= n_dy;
        r_pa <= n_pa;  r_xi <= n_xi;  r_yi <= n_yi;  r_yaw <= n_yaw;
        r_ox <= n_ox;  r_oy <= n_oy;  r_ohead <= n_ohead;  r_olin <= n_olin;
        r_oyaw <= n_oyaw;
    end

endmodule

FILE: tb/odo_pose_checker.sv
// Pose predictor and scoreboard that watches the odometry core's channels.
`timescale 1ns / 1ps

module odo_pose_checker
    import odo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    odo_in_if                     i_item,
    odo_out_if                    i_pose,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int     N_STEPS   = 24;
    localparam longint HALF_TURN = 64'sd843314857;
    localparam longint FULL_TURN = 64'sd1686629713;
    localparam longint QTR_Q30   = 64'sd1686629713;
    localparam longint HALF_Q30  = 64'sd3373259426;
    localparam longint K_GAIN    = 64'sd652032874;
    localparam longint ARC_TAB [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1
    };

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [30:0] heading;
        logic [31:0] linear_speed;
        logic [31:0] yaw_rate;
    } t_pose;

    logic [31:0] speed_scale;
    logic [23:0] inv_track;
    longint      x_pos;
    longint      y_pos;
    longint      head_ang;
    t_pose       pose_q[$];
    int          errors = 0;

    function automatic longint fold_angle(input longint v);
        longint r;
        r = v % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        if (r > HALF_TURN) r -= FULL_TURN;
        return r;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rotation-mode CORDIC; the angle is folded into the right half plane first.
    function automatic void rotate_unit(input longint ang, output longint c, output longint s);
        longint z, x, y, t;
        bit     flip;
        z = ang * 4;
        x = K_GAIN;
        y = 0;
        flip = 1'b0;
        if (z > QTR_Q30) begin
            z -= HALF_Q30;
            flip = 1'b1;
        end else if (z < -QTR_Q30) begin
            z += HALF_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= ARC_TAB[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += ARC_TAB[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_pose advance_pose(input logic signed [15:0] l_rpm,
                                           input logic signed [15:0] r_rpm,
                                           input logic [11:0] dt_ms);
        longint      vl, vr, sum, diff, q, p, d, dth, c, s, dx, dy, xi, yi;
        logic [63:0] mag;
        t_pose       r;
        vl   = longint'(l_rpm) * longint'({32'b0, speed_scale});
        vr   = longint'(r_rpm) * longint'({32'b0, speed_scale});
        sum  = vl + vr;
        diff = vr - vl;

        q   = sum * longint'({52'b0, dt_ms});
        mag = (q < 0) ? 64'(-q) : 64'(q);
        mag = mag / 64'd32768000;
        if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
        d = (q < 0) ? -longint'(mag) : longint'(mag);

        // The heading product wraps at 64 bits before the division.
        p   = diff * longint'({52'b0, dt_ms});
        mag = (p < 0) ? 64'(-p) : 64'(p);
        mag = ((mag >> 20) * {40'b0, inv_track}) / 64'd250;
        dth = (p < 0) ? -longint'(mag) : longint'(mag);
        dth = fold_angle(dth);

        rotate_unit(dth, c, s);
        dx = (c * d) >>> 30;
        dy = (s * d) >>> 30;

        head_ang = fold_angle(head_ang + dth);
        rotate_unit(head_ang, c, s);
        xi = (c * dx - s * dy) >>> 30;
        yi = (s * dx + c * dy) >>> 30;
        x_pos = clamp32(x_pos + xi);
        y_pos = clamp32(y_pos + yi);

        r.pos_x        = x_pos[31:0];
        r.pos_y        = y_pos[31:0];
        r.heading      = head_ang[30:0];
        r.linear_speed = 32'(clamp32(sum >>> 17));
        r.yaw_rate     = 32'(clamp32(((diff >>> 16) * longint'({40'b0, inv_track})) >>> 16));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            speed_scale = '0;
            inv_track   = INV_TRACK_RST;
            x_pos       = 0;
            y_pos       = 0;
            head_ang    = 0;
            pose_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SCALE) speed_scale = i_cfg_data;
                else if (i_cfg_idx == REG_INV_TRACK) inv_track = i_cfg_data[23:0];
            end
            if (i_item.valid && i_item.ready)
                pose_q.push_back(advance_pose(i_item.left_rpm, i_item.right_rpm,
                                              i_item.elapsed_ms));
            if (i_pose.valid && i_pose.ready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected pose transfer x=%h y=%h", $time,
                             i_pose.pos_x, i_pose.pos_y);
                    errors++;
                end else begin
                    want = pose_q.pop_front();
                    if (i_pose.pos_x !== want.pos_x) begin
                        $display("%0t: pos_x expected %h actual %h", $time, want.pos_x,
                                 i_pose.pos_x);
                        errors++;
                    end
                    if (i_pose.pos_y !== want.pos_y) begin
                        $display("%0t: pos_y expected %h actual %h", $time, want.pos_y,
                                 i_pose.pos_y);
                        errors++;
                    end
                    if (i_pose.heading !== want.heading) begin
                        $display("%0t: heading expected %h actual %h", $time, want.heading,
                                 i_pose.heading);
                        errors++;
                    end
                    if (i_pose.linear_speed !== want.linear_speed) begin
                        $display("%0t: linear_speed expected %h actual %h", $time,
                                 want.linear_speed, i_pose.linear_speed);
                        errors++;
                    end
                    if (i_pose.yaw_rate !== want.yaw_rate) begin
                        $display("%0t: yaw_rate expected %h actual %h", $time,
                                 want.yaw_rate, i_pose.yaw_rate);
                        errors++;
                    end
                end
            end
        end
        o_pending <= pose_q.size();
    end

    assign o_errors = errors;

endmodule

FILE: tb/differential_drive_odometry_core_tb.sv
// Stimulus, handshake pacing and verdict for the odometry core testbench.
`timescale 1ns / 1ps

module differential_drive_odometry_core_tb;
    import odo_pkg::*;

    // Indexes past the two real registers; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int N_PHASES   = 8;
    localparam int PER_PHASE  = 210;
    // A quiet stretch well beyond the time one item takes and the long
    // receiver hold-off means the block hung.
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 800;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    quiet_cycles = 0;
    int                    burst_left;
    bit                    hold_request;

    odo_in_if  item_ch();
    odo_out_if pose_ch();

    differential_drive_odometry_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_pose     (pose_ch)
    );

    odo_pose_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .i_pose     (pose_ch),
        .o_errors   (mismatches),
        .o_pending  (outstanding)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Watchdog: any stretch with no transfer and no register write for too
    // long ends the run as a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (item_ch.valid && item_ch.ready) ||
            (pose_ch.valid && pose_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("differential_drive_odometry_core_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: the stall pattern changes every so often between always
    // ready, a coin toss and mostly stalled. A hold-off request blocks the
    // output once for a long count so the core fills and backs up its input.
    initial begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        pose_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(50, 400);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_request && !held) begin
                    pose_ch.ready <= 1'b0;
                    repeat (3000) @(posedge i_clk);
                    held = 1'b1;
                    pose_ch.ready <= 1'b1;
                end else begin
                    case (mode)
                        0:       pose_ch.ready <= 1'b1;
                        1:       pose_ch.ready <= 1'($urandom_range(0, 1));
                        default: pose_ch.ready <= ($urandom_range(0, 7) == 0);
                    endcase
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offers one item and returns at the edge where its transfer happens.
    // Items come in bursts; between bursts valid usually drops for a random gap.
    task automatic send_item(input logic signed [15:0] l_rpm, input logic signed [15:0] r_rpm,
                             input logic [11:0] dt_ms);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                item_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
        item_ch.valid      <= 1'b1;
        item_ch.left_rpm   <= l_rpm;
        item_ch.right_rpm  <= r_rpm;
        item_ch.elapsed_ms <= dt_ms;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // Waits until every expected pose has come back, with valid lowered.
    task automatic drain;
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Random item: mostly well-formed driving (straight runs, turns on the
    // spot, modest speeds), the rest full-range noise.
    task automatic send_random;
        logic signed [15:0] l_rpm;
        logic signed [15:0] r_rpm;
        logic [11:0]        dt_ms;
        case ($urandom_range(0, 4))
            0: begin
                l_rpm = 16'($urandom);
                r_rpm = 16'($urandom);
            end
            1: begin
                l_rpm = 16'($urandom_range(0, 6000) - 3000);
                r_rpm = l_rpm;
            end
            2: begin
                l_rpm = 16'($urandom_range(0, 6000) - 3000);
                r_rpm = -l_rpm;
            end
            default: begin
                l_rpm = 16'($urandom_range(0, 4000) - 2000);
                r_rpm = l_rpm + 16'($urandom_range(0, 400)) - 16'sd200;
            end
        endcase
        case ($urandom_range(0, 5))
            0:       dt_ms = 12'd4095;
            1:       dt_ms = 12'd0;
            2:       dt_ms = 12'($urandom);
            default: dt_ms = 12'($urandom_range(10, 100));
        endcase
        send_item(l_rpm, r_rpm, dt_ms);
    endtask

    initial begin
        logic [31:0] scale_set [N_PHASES];
        logic [31:0] track_set [N_PHASES];
        scale_set = '{32'd429497, 32'hFFFFFFFF, 32'd0, 32'd42950, 32'd4294967,
                      32'd429497, 32'd1000, 32'd0};
        track_set = '{32'd150312, 32'h00FFFFFF, 32'd150312, 32'd0, 32'd65536,
                      32'd16, 32'd150312, 32'd0};
        scale_set[7] = $urandom;
        track_set[7] = $urandom_range(0, 24'hFFFFFF);

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = REG_SCALE;
        i_cfg_data         = '0;
        item_ch.valid      = 1'b0;
        item_ch.left_rpm   = '0;
        item_ch.right_rpm  = '0;
        item_ch.elapsed_ms = '0;
        burst_left         = 0;
        hold_request       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With the reset scale of zero every speed is zero.
        send_item(16'sd32767, -16'sd32768, 12'd4095);
        drain();
        write_reg(REG_SCALE, 32'd429497);
        write_reg(REG_SPARE_A, 32'hFFFFFFFF);
        write_reg(REG_SPARE_B, 32'h12345678);
        send_item(16'sd1000, 16'sd1000, 12'd50);
        send_item(-16'sd1000, -16'sd1000, 12'd50);
        send_item(-16'sd500, 16'sd500, 12'd100);
        send_item(16'sd0, 16'sd0, 12'd4095);
        send_item(16'sd3000, 16'sd3000, 12'd0);
        // Heading steps large enough to wrap many times round.
        send_item(-16'sd32768, 16'sd32767, 12'd4095);
        send_item(16'sd32767, -16'sd32768, 12'd4095);
        send_item(16'sd20000, -16'sd20000, 12'd1234);
        drain();
        // Largest scale and track: the distance step saturates and
        // repeated straight runs drive the position into its limits.
        write_reg(REG_SCALE, 32'hFFFFFFFF);
        write_reg(REG_INV_TRACK, 32'h00FFFFFF);
        send_item(16'sd32767, 16'sd32767, 12'd4095);
        send_item(16'sd32767, 16'sd32767, 12'd4095);
        send_item(16'sd32767, 16'sd32767, 12'd4095);
        send_item(-16'sd32768, -16'sd32768, 12'd4095);
        send_item(-16'sd32768, 16'sd32767, 12'd4095);
        send_item(16'sd1, -16'sd1, 12'd1);
        drain();
        write_reg(REG_INV_TRACK, 32'd0);
        send_item(-16'sd32768, 16'sd32767, 12'd4095);
        send_item(16'sd12345, -16'sd54, 12'd777);
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(REG_SCALE, scale_set[ph]);
            write_reg(REG_INV_TRACK, track_set[ph]);
            if (ph == 1) hold_request = 1'b1;
            repeat (PER_PHASE) send_random();
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("differential_drive_odometry_core_tb: done, clean");
        end else begin
            $display("differential_drive_odometry_core_tb: done, errors");
        end
        $finish;
    end

endmodule
